/* rtl/nmde_pkg.sv */
`default_nettype none

package nmde_pkg;

  localparam int MAX_WIDTH = 4096;
  localparam int LINE_AW   = $clog2(MAX_WIDTH);

  localparam int DIM_W = 13;
  localparam int POS_W = 12;
  localparam int PIX_W = 8;

  localparam logic [DIM_W-1:0] DIM_LIMIT   = 13'd4096;
  localparam logic [DIM_W-1:0] WIDTH_LIMIT = (MAX_WIDTH < 4096) ? DIM_W'(MAX_WIDTH) : DIM_LIMIT;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

  // round((r+g+b)*a/765) == floor(((r+g+b)*a + 382) / 765); the divide is a
  // reciprocal multiply, exact for all sums below 2^18.
  localparam int SUMPROD_W  = 18;
  localparam int RECIP_W    = 19;
  localparam int LUMA_SHIFT = 28;
  localparam logic [SUMPROD_W-1:0] LUMA_ROUND = 18'd382;
  localparam logic [RECIP_W-1:0]   LUMA_RECIP = 19'd350897;

  localparam int CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_FRAME_WIDTH  = 2'd0;
  localparam cfg_idx_t REG_FRAME_HEIGHT = 2'd1;

  // [row: r-2, r-1, r][col: c-2, c-1, c]
  typedef logic [2:0][2:0][PIX_W-1:0] win_t;

  // result slots of one pixel, in send order
  typedef enum logic [1:0] {
    RES_UP_LEFT  = 2'd0,
    RES_UP_HERE  = 2'd1,
    RES_CUR_LEFT = 2'd2,
    RES_CUR_HERE = 2'd3
  } res_t;

endpackage

`default_nettype wire

/* rtl/neighbor_max_difference_edge.sv */
// 3x3 maximum neighbor difference edge detector.
// Input channel (in_valid/in_stall): one RGBA pixel per request, raster order.
// Each pixel is reduced to premultiplied mean luma and kept in a 4096-entry
// line store (two rows per entry). Output channel (out_valid/out_stall):
// edge value of one pixel per request, with its column and row. A pixel's
// result leaves once its 3x3 neighborhood has arrived; pixels at the end of a
// row and in the last row give extra results, up to four per input pixel.
// out_run_last marks the last result caused by a pixel, out_frame_last the
// final result of the frame.
// Pipeline: input register, luma/line read, window and output register stages.
// Throughput: one pixel per cycle while each pixel gives at most one result and
// the receiver does not stall; a pixel giving several results holds the window
// stage and stalls the input until its last result is loaded, as the single
// output register takes one result a cycle.
// When the receiver stalls, the output holds; once a result waits in the window
// stage the whole pipeline freezes and in_stall rises in the same cycle.
// cfg port: index 0 frame_width, 1 frame_height; always ready. Write only
// while idle. Reset clears counters and pipeline, width 640, height 480.
`default_nettype none

module neighbor_max_difference_edge (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire  nmde_pkg::cfg_idx_t      cfg_index,
  input  wire  [nmde_pkg::DIM_W-1:0]    cfg_data,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire  [nmde_pkg::PIX_W-1:0]    in_red,
  input  wire  [nmde_pkg::PIX_W-1:0]    in_green,
  input  wire  [nmde_pkg::PIX_W-1:0]    in_blue,
  input  wire  [nmde_pkg::PIX_W-1:0]    in_alpha,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic [nmde_pkg::POS_W-1:0]    out_col,
  output logic [nmde_pkg::POS_W-1:0]    out_row,
  output logic [nmde_pkg::PIX_W-1:0]    out_edge_value,
  output logic                          out_run_last,
  output logic                          out_frame_last
);
  import nmde_pkg::*;

  function automatic logic [PIX_W-1:0] edge_at(win_t w, logic [1:0] wc, logic [1:0] wr,
                                               logic up, logic dn, logic lf, logic rt);
    logic [PIX_W-1:0] best;
    logic [PIX_W-1:0] ctr;
    logic [PIX_W-1:0] n;
    logic [PIX_W-1:0] d;
    int rr;
    int cc;
    logic skip;
    best = '0;
    ctr  = w[wr][wc];
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        rr   = int'(wr) + dr;
        cc   = int'(wc) + dc;
        skip = (dr == 0 && dc == 0) || (dr < 0 && !up) || (dr > 0 && !dn) ||
               (dc < 0 && !lf) || (dc > 0 && !rt) || rr > 2 || cc > 2;
        n    = w[rr[1:0]][cc[1:0]];
        d    = (n > ctr) ? n - ctr : ctr - n;
        if (!skip && d > best) begin
          best = d;
        end
      end
    end
    return best;
  endfunction

  // configuration
  logic [DIM_W-1:0] frame_width_r;
  logic [DIM_W-1:0] frame_height_r;
  logic [DIM_W-1:0] width_eff;
  logic [DIM_W-1:0] height_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= WIDTH_RESET;
      frame_height_r <= HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_FRAME_WIDTH) begin
        frame_width_r <= cfg_data;
      end
      if (cfg_index == REG_FRAME_HEIGHT) begin
        frame_height_r <= cfg_data;
      end
    end
  end

  always_comb begin
    if (frame_width_r == '0) begin
      width_eff = DIM_W'(1);
    end else if (frame_width_r > WIDTH_LIMIT) begin
      width_eff = WIDTH_LIMIT;
    end else begin
      width_eff = frame_width_r;
    end
    if (frame_height_r == '0) begin
      height_eff = DIM_W'(1);
    end else if (frame_height_r > DIM_LIMIT) begin
      height_eff = DIM_LIMIT;
    end else begin
      height_eff = frame_height_r;
    end
  end

  // pipeline control
  logic adv;
  logic accept;

  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  // position counters
  logic [POS_W-1:0] col_r, row_r;
  logic [POS_W-1:0] col_nxt, row_nxt;
  logic             last_col, last_row;

  assign last_col = (DIM_W'(col_r) + DIM_W'(1)) >= width_eff;
  assign last_row = (DIM_W'(row_r) + DIM_W'(1)) >= height_eff;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + POS_W'(1);
      end else begin
        col_nxt = col_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // stage 1: sum times alpha
  logic                 v1_r;
  logic [SUMPROD_W-1:0] p1_r;
  logic [POS_W-1:0]     c1_r, r1_r;
  logic                 lc1_r, lr1_r;
  logic [9:0]           rgb_sum;

  assign rgb_sum = 10'(in_red) + 10'(in_green) + 10'(in_blue);

  // stage 2: luma, line store read
  logic                 v2_r;
  logic [PIX_W-1:0]     lum2_r;
  logic [POS_W-1:0]     c2_r, r2_r;
  logic                 lc2_r, lr2_r;
  logic [2*PIX_W-1:0]   line_rd_r;
  logic                 fwd_r;
  logic [2*PIX_W-1:0]   fwd_data_r;
  logic [2*PIX_W-1:0]   line_eff;
  logic [SUMPROD_W+RECIP_W-1:0] luma_prod;
  logic [PIX_W-1:0]     lum_nxt;
  logic                 fwd_nxt;

  assign luma_prod = (SUMPROD_W+RECIP_W)'(p1_r) * (SUMPROD_W+RECIP_W)'(LUMA_RECIP);
  assign lum_nxt   = luma_prod[LUMA_SHIFT +: PIX_W];
  // {older, newer} of the column that stage 2 holds
  assign line_eff  = fwd_r ? fwd_data_r : line_rd_r;
  // stage 2 writes the column that stage 1 reads on the same edge
  assign fwd_nxt   = v1_r && v2_r && (c1_r == c2_r);

  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (adv && v2_r) begin
      line_mem[c2_r[LINE_AW-1:0]] <= {line_eff[PIX_W-1:0], lum2_r};
    end
    if (adv) begin
      line_rd_r <= line_mem[c1_r[LINE_AW-1:0]];
    end
  end

  // stage 3: window
  logic             v3_r;
  win_t             win_r, win_nxt;
  logic [POS_W-1:0] c3_r, r3_r;
  logic             lc3_r, lr3_r;
  logic [3:0]       sent_r;

  always_comb begin
    win_nxt = win_r;
    for (int i = 0; i < 3; i++) begin
      win_nxt[i][0] = win_r[i][1];
      win_nxt[i][1] = win_r[i][2];
    end
    win_nxt[0][2] = line_eff[2*PIX_W-1:PIX_W];
    win_nxt[1][2] = line_eff[PIX_W-1:0];
    win_nxt[2][2] = lum2_r;
  end

  // result selection
  logic [3:0]       res_mask, pending, sel_oh, pend_rest;
  res_t             res_idx;
  logic             res_last;
  logic             out_load;
  logic             r3_done;
  logic [POS_W-1:0] res_col, res_row;
  logic [1:0]       wc, wr;
  logic             up, dn, lf, rt;
  logic [PIX_W-1:0] res_edge;

  assign res_mask[RES_UP_LEFT]  = (r3_r != '0) && (c3_r != '0);
  assign res_mask[RES_UP_HERE]  = (r3_r != '0) && lc3_r;
  assign res_mask[RES_CUR_LEFT] = lr3_r && (c3_r != '0);
  assign res_mask[RES_CUR_HERE] = lr3_r && lc3_r;
  assign pending = v3_r ? (res_mask & ~sent_r) : '0;

  always_comb begin
    priority if (pending[RES_UP_LEFT]) begin
      res_idx = RES_UP_LEFT;
    end else if (pending[RES_UP_HERE]) begin
      res_idx = RES_UP_HERE;
    end else if (pending[RES_CUR_LEFT]) begin
      res_idx = RES_CUR_LEFT;
    end else begin
      res_idx = RES_CUR_HERE;
    end
  end

  assign sel_oh    = 4'b0001 << res_idx;
  assign pend_rest = pending & ~sel_oh;
  assign res_last  = (pend_rest == '0);

  always_comb begin
    unique case (res_idx)
      RES_UP_LEFT: begin
        res_col = c3_r - POS_W'(1); res_row = r3_r - POS_W'(1);
        wc = 2'd1; wr = 2'd1;
        up = r3_r > POS_W'(1); dn = 1'b1; lf = c3_r > POS_W'(1); rt = 1'b1;
      end
      RES_UP_HERE: begin
        res_col = c3_r; res_row = r3_r - POS_W'(1);
        wc = 2'd2; wr = 2'd1;
        up = r3_r > POS_W'(1); dn = 1'b1; lf = c3_r != '0; rt = 1'b0;
      end
      RES_CUR_LEFT: begin
        res_col = c3_r - POS_W'(1); res_row = r3_r;
        wc = 2'd1; wr = 2'd2;
        up = r3_r != '0; dn = 1'b0; lf = c3_r > POS_W'(1); rt = 1'b1;
      end
      default: begin
        res_col = c3_r; res_row = r3_r;
        wc = 2'd2; wr = 2'd2;
        up = r3_r != '0; dn = 1'b0; lf = c3_r != '0; rt = 1'b0;
      end
    endcase
  end

  assign res_edge = edge_at(win_r, wc, wr, up, dn, lf, rt);

  // output register
  logic             out_valid_r;
  logic [POS_W-1:0] out_col_r, out_row_r;
  logic [PIX_W-1:0] out_edge_r;
  logic             out_run_last_r, out_frame_last_r;

  assign out_load = !out_valid_r || !out_stall;
  assign r3_done  = v3_r && ((pending == '0) || (out_load && res_last));
  assign adv      = !v3_r || r3_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      fwd_r       <= 1'b0;
      sent_r      <= '0;
      win_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        v1_r   <= accept;
        v2_r   <= v1_r;
        v3_r   <= v2_r;
        fwd_r  <= fwd_nxt;
        sent_r <= '0;
        if (v2_r) begin
          win_r <= win_nxt;
        end
      end else if (out_load && pending != '0) begin
        sent_r <= sent_r | sel_oh;
      end
      if (out_load) begin
        out_valid_r <= (pending != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r       <= SUMPROD_W'(rgb_sum) * SUMPROD_W'(in_alpha) + LUMA_ROUND;
      c1_r       <= col_r;
      r1_r       <= row_r;
      lc1_r      <= last_col;
      lr1_r      <= last_row;
      lum2_r     <= lum_nxt;
      c2_r       <= c1_r;
      r2_r       <= r1_r;
      lc2_r      <= lc1_r;
      lr2_r      <= lr1_r;
      fwd_data_r <= {line_eff[PIX_W-1:0], lum2_r};
      c3_r       <= c2_r;
      r3_r       <= r2_r;
      lc3_r      <= lc2_r;
      lr3_r      <= lr2_r;
    end
    if (out_load && pending != '0) begin
      out_col_r        <= res_col;
      out_row_r        <= res_row;
      out_edge_r       <= res_edge;
      out_run_last_r   <= res_last;
      out_frame_last_r <= res_last && lc3_r && lr3_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_col        = out_col_r;
  assign out_row        = out_row_r;
  assign out_edge_value = out_edge_r;
  assign out_run_last   = out_run_last_r;
  assign out_frame_last = out_frame_last_r;

  a_sent_in_mask: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> ((sent_r & ~res_mask) == '0))
    else $error("result slot marked sent that the pixel never produces");

  a_sent_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !v3_r |-> (sent_r == '0))
    else $error("sent slots left over with no pixel in the window stage");

  a_frame_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_last) |-> out_run_last)
    else $error("frame end flagged on a result that is not last of its pixel");

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !adv) |=> (v3_r && $stable(c3_r) && $stable(r3_r)))
    else $error("window stage changed while held");

endmodule

`default_nettype wire

/* tb/tb_neighbor_max_difference_edge.sv */
`default_nettype none

module tb_neighbor_max_difference_edge;
  timeunit 1ns;
  timeprecision 1ps;

  import nmde_pkg::*;

  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 90;
  localparam int PHASE_PIXELS  = 60;

  typedef struct packed {
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic [PIX_W-1:0] diff;
    logic             run_last;
    logic             frame_last;
  } edge_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  cfg_idx_t         cfg_index = REG_FRAME_WIDTH;
  logic [DIM_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [PIX_W-1:0] in_red = '0;
  logic [PIX_W-1:0] in_green = '0;
  logic [PIX_W-1:0] in_blue = '0;
  logic [PIX_W-1:0] in_alpha = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [POS_W-1:0] out_col;
  logic [POS_W-1:0] out_row;
  logic [PIX_W-1:0] out_edge_value;
  logic             out_run_last;
  logic             out_frame_last;

  // shadow of the block: registers, line stores, window, raster position
  logic [DIM_W-1:0] width_reg = WIDTH_RESET;
  logic [DIM_W-1:0] height_reg = HEIGHT_RESET;
  bit   [PIX_W-1:0] luma_prev2 [MAX_WIDTH];
  bit   [PIX_W-1:0] luma_prev1 [MAX_WIDTH];
  bit   [PIX_W-1:0] win [3][3];
  logic [POS_W-1:0] next_col = '0;
  logic [POS_W-1:0] next_row = '0;
  edge_result_t     pending_edges [$];
  edge_result_t     want_edge;

  int send_idle_pct = 28;
  int recv_stall_pct = 76;
  bit recv_hold = 1'b0;
  int mismatches = 0;
  int pixels_sent = 0;
  int results_checked = 0;
  int frames_closed = 0;
  int in_held_cycles = 0;

  neighbor_max_difference_edge DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_alpha       (in_alpha),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_col        (out_col),
    .out_row        (out_row),
    .out_edge_value (out_edge_value),
    .out_run_last   (out_run_last),
    .out_frame_last (out_frame_last)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= recv_hold || ($urandom_range(99) < recv_stall_pct);
  end

  function automatic int clamp_size(logic [DIM_W-1:0] value, int limit);
    if (value == 0) return 1;
    if (value > limit) return limit;
    return value;
  endfunction

  function automatic logic [PIX_W-1:0] window_max_diff(int wc, int wr, bit up, bit down,
                                                       bit left, bit right);
    int best, d, rr, cc;
    best = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        rr = wr + dr;
        cc = wc + dc;
        if ((dr == 0 && dc == 0) || (dr < 0 && !up) || (dr > 0 && !down) ||
            (dc < 0 && !left) || (dc > 0 && !right) ||
            rr < 0 || rr > 2 || cc < 0 || cc > 2)
          continue;
        d = int'(win[rr][cc]) - int'(win[wr][wc]);
        if (d < 0) d = -d;
        if (d > best) best = d;
      end
    end
    return best[PIX_W-1:0];
  endfunction

  function automatic edge_result_t located_edge(int col, int row, logic [PIX_W-1:0] diff);
    edge_result_t res;
    res.col = col[POS_W-1:0];
    res.row = row[POS_W-1:0];
    res.diff = diff;
    res.run_last = 1'b0;
    res.frame_last = 1'b0;
    return res;
  endfunction

  // Slide the window, update the line stores and queue every result the pixel completes.
  function automatic void predict_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                        logic [PIX_W-1:0] b, logic [PIX_W-1:0] a);
    int w, h, lum, c, rw, k;
    bit lastc, lastr;
    edge_result_t res [4];
    w = clamp_size(width_reg, int'(WIDTH_LIMIT));
    h = clamp_size(height_reg, int'(DIM_LIMIT));
    lum = ((int'(r) + int'(g) + int'(b)) * int'(a) * 2 + 765) / 1530;
    c = next_col;
    rw = next_row;
    lastc = (c + 1 >= w);
    lastr = (rw + 1 >= h);
    k = 0;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = luma_prev2[c];
    win[1][2] = luma_prev1[c];
    win[2][2] = lum[PIX_W-1:0];
    luma_prev2[c] = luma_prev1[c];
    luma_prev1[c] = lum[PIX_W-1:0];
    if (rw >= 1) begin
      if (c >= 1) begin
        res[k] = located_edge(c - 1, rw - 1, window_max_diff(1, 1, rw >= 2, 1, c >= 2, 1));
        k++;
      end
      if (lastc) begin
        res[k] = located_edge(c, rw - 1, window_max_diff(2, 1, rw >= 2, 1, c >= 1, 0));
        k++;
      end
    end
    if (lastr) begin
      if (c >= 1) begin
        res[k] = located_edge(c - 1, rw, window_max_diff(1, 2, rw >= 1, 0, c >= 2, 1));
        k++;
      end
      if (lastc) begin
        res[k] = located_edge(c, rw, window_max_diff(2, 2, rw >= 1, 0, c >= 1, 0));
        k++;
      end
    end
    if (k > 0) begin
      res[k-1].run_last = 1'b1;
      res[k-1].frame_last = lastr && lastc;
    end
    for (int i = 0; i < k; i++) pending_edges.push_back(res[i]);
    if (lastc) begin
      next_col = '0;
      next_row = lastr ? '0 : POS_W'(rw + 1);
    end else begin
      next_col = POS_W'(c + 1);
    end
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at result %0d: %s", results_checked, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s of pixel (%0d,%0d) is %0d, expected %0d",
                                name, want_edge.col, want_edge.row, got, want));
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_stall) in_held_cycles++;
      if (out_valid && !out_stall) begin
        if (pending_edges.size() == 0) begin
          report_mismatch($sformatf("result for (%0d,%0d) with nothing outstanding",
                                    out_col, out_row));
        end else begin
          want_edge = pending_edges.pop_front();
          check_field("column", out_col, want_edge.col);
          check_field("row", out_row, want_edge.row);
          check_field("edge value", out_edge_value, want_edge.diff);
          check_field("run_last", out_run_last, want_edge.run_last);
          check_field("frame_last", out_frame_last, want_edge.frame_last);
          if (want_edge.frame_last) frames_closed++;
        end
        results_checked++;
      end
    end
  end

  task automatic send_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                            logic [PIX_W-1:0] b, logic [PIX_W-1:0] a);
    in_valid <= 1'b1;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    in_alpha <= a;
    do @(posedge clk); while (in_stall);
    predict_pixel(r, g, b, a);
    pixels_sent++;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_random_pixel();
    logic [PIX_W-1:0] ch [4];
    bit stark;
    // a quarter of the pixels use only 0 and 255 per channel for large steps
    stark = ($urandom_range(3) == 0);
    for (int i = 0; i < 4; i++)
      ch[i] = stark ? {PIX_W{$urandom_range(1) == 1}} : PIX_W'($urandom);
    send_pixel(ch[0], ch[1], ch[2], ch[3]);
  endtask

  task automatic finish_frame();
    do send_random_pixel(); while (next_col != 0 || next_row != 0);
  endtask

  task automatic set_frame(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    cfg_valid <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data <= w;
    do @(posedge clk); while (!cfg_ready);
    width_reg = w;
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data <= h;
    do @(posedge clk); while (!cfg_ready);
    height_reg = h;
    cfg_valid <= 1'b0;
  endtask

  // Row-0 pixels of taller frames give no result; pad past the pipeline after draining.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [DIM_W-1:0] size_code(int n);
    if (n == 1 && $urandom_range(1) == 1) return '0;
    return DIM_W'(n);
  endfunction

  task automatic test_power_on_size();
    // wide rows out of reset: a few pixels stay in the first row, then a
    // narrow size puts the column past the last one
    repeat (5) send_random_pixel();
    settle();
    set_frame(13'd3, 13'd3);
    finish_frame();
  endtask

  task automatic test_lone_pixel();
    settle();
    set_frame(13'd0, 13'd0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
    settle();
    set_frame(13'd1, 13'd1);
    send_pixel(8'd128, 8'd64, 8'd32, 8'd200);
  endtask

  task automatic test_single_line_frames();
    settle();
    set_frame(13'd1, 13'd3);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00);
    send_pixel(8'hFF, 8'h00, 8'h00, 8'hFF);
    settle();
    // luma rounding below and above one half
    set_frame(13'd4, 13'd1);
    send_pixel(8'd1, 8'd0, 8'd0, 8'hFF);
    send_pixel(8'd2, 8'd0, 8'd0, 8'hFF);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'd1);
    send_pixel(8'h00, 8'h00, 8'h00, 8'hFF);
  endtask

  task automatic test_checkerboard();
    settle();
    set_frame(13'd3, 13'd3);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) send_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00);
      else if (i % 2 == 1) send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      else send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
    end
  endtask

  task automatic test_mid_frame_resize();
    settle();
    set_frame(13'd4, 13'd4);
    repeat (6) send_random_pixel();
    settle();
    // column 2 now lies beyond the last column
    set_frame(13'd2, 13'd4);
    send_random_pixel();
    settle();
    // row 2 now lies beyond the last row: last pixel gives four results
    set_frame(13'd2, 13'd2);
    finish_frame();
  endtask

  task automatic run_random_frames(int quota);
    int first, w, h, cut;
    first = pixels_sent;
    while (pixels_sent - first < quota) begin
      w = ($urandom_range(7) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
      h = $urandom_range(6, 1);
      settle();
      set_frame(size_code(w), size_code(h));
      if ($urandom_range(4) == 0 && w * h > 1) begin
        // cut the frame short with a new size; widen only within the first row
        cut = $urandom_range(w * h - 1, 1);
        repeat (cut) send_random_pixel();
        settle();
        w = (next_row == 0) ? $urandom_range(12, 1) : $urandom_range(w, 1);
        h = $urandom_range(6, 1);
        set_frame(size_code(w), size_code(h));
      end
      finish_frame();
    end
  endtask

  task automatic test_random_traffic();
    send_idle_pct = 28;
    recv_stall_pct = 76;
    run_random_frames(PHASE_PIXELS);
    send_idle_pct = 76;
    recv_stall_pct = 28;
    run_random_frames(PHASE_PIXELS);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random_frames(PHASE_PIXELS);
  endtask

  task automatic test_output_hold();
    settle();
    set_frame(13'd10, 13'd6);
    fork
      begin
        recv_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        recv_hold = 1'b0;
      end
    join_none
    finish_frame();
  endtask

  task automatic test_size_limits();
    settle();
    // width register over range: a few pixels into the first row, then shrink
    set_frame(13'h1FFF, 13'd2);
    repeat (6) send_random_pixel();
    settle();
    set_frame(13'd4, 13'd2);
    finish_frame();
    settle();
    // tallest frame, one pixel wide: a few rows, then a zero height ends it
    set_frame(13'd0, 13'd4096);
    repeat (6) send_random_pixel();
    settle();
    set_frame(13'd1, 13'd0);
    finish_frame();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_power_on_size();
    test_lone_pixel();
    test_single_line_frames();
    test_checkerboard();
    test_mid_frame_resize();
    test_random_traffic();
    test_output_hold();
    test_size_limits();
    settle();
    $display("Sent %0d pixels over %0d frames, compared %0d edge results (%0d mismatches).",
             pixels_sent, frames_closed, results_checked, mismatches);
    $display("Frames 1x1 to 40 wide, sizes 0 and over range, resized mid-frame; %0d held.",
             in_held_cycles);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire
